/* rtl/fobb_pkg.sv */
// ----------------------------------------------------------------------------
// fobb_pkg
// Shared widths, register indexes, class codes and payload types for the
// oriented box frustum classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package fobb_pkg;

   localparam int PLANE_COUNT    = 6;
   localparam int NUM_PLANE_REGS = 6;

   localparam int COORD_W     = 24;
   localparam int NORM_W      = 12;
   localparam int OFFS_W      = 28;
   localparam int MARGIN_W    = 23;
   localparam int PLANE_REG_W = 64;
   localparam int FRAC_SHIFT  = 10;
   localparam int PROD_W      = COORD_W + NORM_W;
   localparam int DOT_W       = PROD_W + 2;
   localparam int ACC_W       = DOT_W + 3;
   localparam int CSR_IDX_W   = 3;
   localparam int CLASS_W     = 2;

   localparam int VEC_COUNT   = 4;
   localparam int COORD_COUNT = VEC_COUNT * 3;

   localparam int NORM_X_LSB  = 0;
   localparam int NORM_Y_LSB  = NORM_W;
   localparam int NORM_Z_LSB  = 2 * NORM_W;
   localparam int OFFS_LSB    = 3 * NORM_W;

   localparam logic [CSR_IDX_W-1:0] REG_PLANE_LEFT     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_PLANE_FAR      = CSR_IDX_W'(NUM_PLANE_REGS - 1);
   localparam logic [CSR_IDX_W-1:0] REG_OUTSIDE_MARGIN = CSR_IDX_W'(NUM_PLANE_REGS);

   localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(512);

   localparam logic [CLASS_W-1:0] CLASS_INSIDE   = CLASS_W'(0);
   localparam logic [CLASS_W-1:0] CLASS_SPANNING = CLASS_W'(1);
   localparam logic [CLASS_W-1:0] CLASS_OUTSIDE  = CLASS_W'(2);

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type center_x;
      coord_type center_y;
      coord_type center_z;
      coord_type half_axis0_x;
      coord_type half_axis0_y;
      coord_type half_axis0_z;
      coord_type half_axis1_x;
      coord_type half_axis1_y;
      coord_type half_axis1_z;
      coord_type half_axis2_x;
      coord_type half_axis2_y;
      coord_type half_axis2_z;
   } req_payload_type;

   typedef struct packed {
      logic [CLASS_W-1:0] position_class;
   } rsp_payload_type;

   typedef struct packed {
      logic outside;
      logic span;
   } plane_flags_type;

endpackage

`default_nettype wire

/* rtl/fobb_if.sv */
// ----------------------------------------------------------------------------
// fobb_if
// Valid/ready channel interfaces for box requests and class responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface fobb_req_if import fobb_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface fobb_rsp_if import fobb_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/frustum_obb_classifier.sv */
// ----------------------------------------------------------------------------
// frustum_obb_classifier
// Oriented box versus frustum classifier, one box per clock unless the response stalls.
// ----------------------------------------------------------------------------
// The block takes one box per clock and returns one position class per box,
// in order: 0 inside, 1 spanning a plane, 2 fully outside. Response valid
// rises after the request has passed through five registers:
// input register, product register, dot-product register, radius/distance
// register, result register.
// Every plane runs its own multipliers, so a new box enters each cycle; the
// whole pipe holds only while the response register is full and not taken.
// Plane and margin registers are written through the csr port; the user must
// write them only while the block is idle, which the block itself does not enforce; index 7 is ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_obb_classifier import fobb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   fobb_req_if.sink               req_bus,
   fobb_rsp_if.source             rsp_bus,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [PLANE_REG_W-1:0] csr_wdata
);

   logic [PLANE_REG_W-1:0] plane_ff [NUM_PLANE_REGS];
   logic [MARGIN_W-1:0]    margin_ff;

   coord_type              in_ff [COORD_COUNT];
   coord_type              in_in [COORD_COUNT];
   logic [3:0]             stage_valid_ff;
   logic                   rsp_valid_ff;
   logic [CLASS_W-1:0]     class_ff, class_in;
   logic                   advance;

   plane_flags_type        flags [PLANE_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PLANE_REGS; i++) begin
            plane_ff[i] <= '0;
         end
         margin_ff <= MARGIN_RESET;
      end else if (csr_we) begin
         if (csr_index inside {[REG_PLANE_LEFT:REG_PLANE_FAR]}) begin
            plane_ff[csr_index] <= csr_wdata;
         end else if (csr_index == REG_OUTSIDE_MARGIN) begin
            margin_ff <= csr_wdata[MARGIN_W-1:0];
         end
      end
   end

   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;

   assign in_in[0]  = req_bus.data.center_x;
   assign in_in[1]  = req_bus.data.center_y;
   assign in_in[2]  = req_bus.data.center_z;
   assign in_in[3]  = req_bus.data.half_axis0_x;
   assign in_in[4]  = req_bus.data.half_axis0_y;
   assign in_in[5]  = req_bus.data.half_axis0_z;
   assign in_in[6]  = req_bus.data.half_axis1_x;
   assign in_in[7]  = req_bus.data.half_axis1_y;
   assign in_in[8]  = req_bus.data.half_axis1_z;
   assign in_in[9]  = req_bus.data.half_axis2_x;
   assign in_in[10] = req_bus.data.half_axis2_y;
   assign in_in[11] = req_bus.data.half_axis2_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else if (advance) begin
         stage_valid_ff <= {stage_valid_ff[2:0], req_bus.valid};
         rsp_valid_ff   <= stage_valid_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_ff    <= in_in;
         class_ff <= class_in;
      end
   end

   for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
      fobb_plane_eval u_plane (
         .clock   (clock),
         .advance (advance),
         .coords  (in_ff),
         .plane   (plane_ff[p]),
         .margin  (margin_ff),
         .flags   (flags[p])
      );
   end

   always_comb begin
      logic any_out;
      logic any_span;
      any_out  = 1'b0;
      any_span = 1'b0;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         any_out  = any_out  | flags[p].outside;
         any_span = any_span | flags[p].span;
      end
      if (any_out) begin
         class_in = CLASS_OUTSIDE;
      end else if (any_span) begin
         class_in = CLASS_SPANNING;
      end else begin
         class_in = CLASS_INSIDE;
      end
   end

   assign rsp_bus.valid               = rsp_valid_ff;
   assign rsp_bus.data.position_class = class_ff;

endmodule

`default_nettype wire

/* rtl/fobb_plane_eval.sv */
// ----------------------------------------------------------------------------
// fobb_plane_eval
// One plane test: registered products, registered dot products, registered
// projected radius and center distance, then the outside/span compares.
// ----------------------------------------------------------------------------
`default_nettype none

module fobb_plane_eval import fobb_pkg::*; (
   input  logic                   clock,
   input  logic                   advance,
   input  coord_type              coords [COORD_COUNT],
   input  logic [PLANE_REG_W-1:0] plane,
   input  logic [MARGIN_W-1:0]    margin,
   output plane_flags_type        flags
);

   logic signed [NORM_W-1:0]  norm [3];
   logic signed [ACC_W-1:0]   offs_scaled;
   logic signed [ACC_W-1:0]   margin_scaled;
   logic signed [ACC_W-1:0]   outside_sum;

   logic signed [PROD_W-1:0]  prod_ff [VEC_COUNT][3];
   logic signed [PROD_W-1:0]  prod_in [VEC_COUNT][3];
   logic signed [DOT_W-1:0]   dot_ff  [VEC_COUNT];
   logic signed [DOT_W-1:0]   dot_in  [VEC_COUNT];
   logic signed [ACC_W-1:0]   r_ff, r_in;
   logic signed [ACC_W-1:0]   s_ff, s_in;

   assign norm[0] = plane[NORM_X_LSB +: NORM_W];
   assign norm[1] = plane[NORM_Y_LSB +: NORM_W];
   assign norm[2] = plane[NORM_Z_LSB +: NORM_W];

   assign offs_scaled   = ACC_W'($signed({plane[OFFS_LSB +: OFFS_W], {FRAC_SHIFT{1'b0}}}));
   assign margin_scaled = ACC_W'({margin, {FRAC_SHIFT{1'b0}}});

   always_comb begin
      for (int k = 0; k < VEC_COUNT; k++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[k][c] = PROD_W'(coords[3 * k + c]) * PROD_W'(norm[c]);
         end
      end
   end

   always_comb begin
      logic signed [DOT_W-1:0] sum_v;
      for (int k = 0; k < VEC_COUNT; k++) begin
         sum_v = DOT_W'(prod_ff[k][0]) + DOT_W'(prod_ff[k][1]) + DOT_W'(prod_ff[k][2]);
         if (k != 0 && sum_v < 0) begin
            dot_in[k] = -sum_v;
         end else begin
            dot_in[k] = sum_v;
         end
      end
   end

   assign r_in = ACC_W'(dot_ff[1]) + ACC_W'(dot_ff[2]) + ACC_W'(dot_ff[3]);
   assign s_in = ACC_W'(dot_ff[0]) + offs_scaled;

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         dot_ff  <= dot_in;
         r_ff    <= r_in;
         s_ff    <= s_in;
      end
   end

   // outside when s + margin < -r
   assign outside_sum   = s_ff + margin_scaled + r_ff;
   assign flags.outside = outside_sum[ACC_W-1];
   assign flags.span    = (s_ff <= r_ff);

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Randomized check of the oriented box frustum classifier against a mirror.
// ----------------------------------------------------------------------------
// Loads plane sets and margins through the csr port while the pipe is empty,
// streams boxes through the request channel with random gaps, and compares
// each response class with a class predicted from the mirrored registers.
// Directed boxes cover field extremes, all-zero planes, the distance and
// margin boundaries, outside winning over spanning, unnormalized normals,
// the ignored register index and margin masking.
// ----------------------------------------------------------------------------
module testbench import fobb_pkg::*; ();

   localparam int PIPE_LATENCY    = 5;
   localparam int IDLE_LIMIT      = 2000;
   localparam int PHASE_COUNT     = 8;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int MAX_REPORTS     = 50;
   localparam int UNIT            = 256;
   localparam int NORM_ONE        = 1 << FRAC_SHIFT;
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = REG_OUTSIDE_MARGIN + 1'b1;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef enum int {PLANES_AXIS, PLANES_TILTED, PLANES_RAW, PLANES_EXTREME} plane_set_kind_type;

   class obb_tracker_type;
      logic [PLANE_REG_W-1:0] plane_word [NUM_PLANE_REGS];
      logic [MARGIN_W-1:0]    margin;
      logic [CLASS_W-1:0]     pending_classes [$];
      int unsigned            mismatches;
      int unsigned            boxes_checked;

      function new();
         foreach (plane_word[p]) plane_word[p] = '0;
         margin = MARGIN_RESET;
         mismatches = 0;
         boxes_checked = 0;
      endfunction

      function void store_register(logic [CSR_IDX_W-1:0] index,
                                   logic [PLANE_REG_W-1:0] value);
         if (index < REG_OUTSIDE_MARGIN) begin
            plane_word[index] = value;
         end else if (index == REG_OUTSIDE_MARGIN) begin
            margin = value[MARGIN_W-1:0];
         end
      endfunction

      function logic [CLASS_W-1:0] predict_class(req_payload_type box);
         longint ctr [3];
         longint ax [3][3];
         longint nrm [3];
         logic signed [NORM_W-1:0] npart;
         logic signed [OFFS_W-1:0] opart;
         longint offs, radius, ctr_dist, slack, proj;
         bit any_outside, any_span;
         any_outside = 0;
         any_span = 0;
         ctr[0] = box.center_x;
         ctr[1] = box.center_y;
         ctr[2] = box.center_z;
         ax[0][0] = box.half_axis0_x;
         ax[0][1] = box.half_axis0_y;
         ax[0][2] = box.half_axis0_z;
         ax[1][0] = box.half_axis1_x;
         ax[1][1] = box.half_axis1_y;
         ax[1][2] = box.half_axis1_z;
         ax[2][0] = box.half_axis2_x;
         ax[2][1] = box.half_axis2_y;
         ax[2][2] = box.half_axis2_z;
         slack = longint'(margin) * NORM_ONE;
         for (int p = 0; p < PLANE_COUNT && p < NUM_PLANE_REGS; p++) begin
            npart = plane_word[p][NORM_X_LSB +: NORM_W];
            nrm[0] = npart;
            npart = plane_word[p][NORM_Y_LSB +: NORM_W];
            nrm[1] = npart;
            npart = plane_word[p][NORM_Z_LSB +: NORM_W];
            nrm[2] = npart;
            opart = plane_word[p][OFFS_LSB +: OFFS_W];
            offs = longint'(opart) * NORM_ONE;
            radius = 0;
            for (int a = 0; a < 3; a++) begin
               proj = nrm[0] * ax[a][0] + nrm[1] * ax[a][1] + nrm[2] * ax[a][2];
               radius += (proj < 0) ? -proj : proj;
            end
            ctr_dist = nrm[0] * ctr[0] + nrm[1] * ctr[1] + nrm[2] * ctr[2] + offs;
            if (ctr_dist <= radius) any_span = 1;
            if (ctr_dist + slack < -radius) any_outside = 1;
         end
         if (any_outside) return CLASS_OUTSIDE;
         if (any_span) return CLASS_SPANNING;
         return CLASS_INSIDE;
      endfunction

      function void note_box(req_payload_type box);
         pending_classes.push_back(predict_class(box));
      endfunction

      function int pending();
         return pending_classes.size();
      endfunction

      task report_mismatch(string what);
         if (mismatches < MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, what);
         mismatches++;
      endtask

      task check_class(rsp_payload_type rsp);
         logic [CLASS_W-1:0] want;
         if (pending_classes.size() == 0) begin
            report_mismatch($sformatf("class %0d with no box in flight", rsp.position_class));
         end else begin
            want = pending_classes.pop_front();
            if (rsp.position_class !== want) begin
               report_mismatch($sformatf("box %0d: class %0d, predicted %0d",
                                         boxes_checked, rsp.position_class, want));
            end
            boxes_checked++;
         end
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [PLANE_REG_W-1:0] csr_wdata;

   fobb_req_if req_bus ();
   fobb_rsp_if rsp_bus ();

   frustum_obb_classifier uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   obb_tracker_type tracker = new();

   bit sender_gaps;
   bit receiver_stalls;
   int stall_left;
   int idle_cycles;
   bit moved;

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic coord_type rand_coord(int unsigned span);
      return coord_type'(int'($urandom_range(0, 2 * span)) - int'(span));
   endfunction

   function automatic coord_type edge_coord();
      case ($urandom_range(3))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return '0;
         default: return '1;
      endcase
   endfunction

   function automatic req_payload_type random_box();
      req_payload_type box;
      coord_type f;
      int r;
      r = $urandom_range(99);
      for (int i = 0; i < COORD_COUNT; i++) begin
         if (r < 55) f = rand_coord((i < 3) ? 200 * UNIT : 24 * UNIT);
         else if (r < 80) f = rand_coord((i < 3) ? (1 << 20) : (1 << 16));
         else if (r < 92) f = coord_type'($urandom);
         else f = edge_coord();
         box[(COORD_COUNT - 1 - i) * COORD_W +: COORD_W] = f;
      end
      return box;
   endfunction

   function automatic req_payload_type box_at(int cx, int cy, int cz);
      req_payload_type box;
      box = '0;
      box.center_x = coord_type'(cx);
      box.center_y = coord_type'(cy);
      box.center_z = coord_type'(cz);
      return box;
   endfunction

   function automatic logic [PLANE_REG_W-1:0] pack_plane(int nx, int ny, int nz, int offs);
      return {OFFS_W'(offs), NORM_W'(nz), NORM_W'(ny), NORM_W'(nx)};
   endfunction

   // monitor and watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         moved = 0;
         if (req_bus.valid && req_bus.ready) begin
            tracker.note_box(req_bus.data);
            moved = 1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            tracker.check_class(rsp_bus.data);
            moved = 1;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("testbench: FAIL");
            $finish;
         end
      end
   end

   // response side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (receiver_stalls) stall_left = pick_gap();
      end
   end

   task send_box(input req_payload_type box);
      int gap;
      req_bus.data <= box;
      req_bus.valid <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      gap = sender_gaps ? pick_gap() : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
      repeat (PIPE_LATENCY) @(posedge clock);
   endtask

   task write_register(input logic [CSR_IDX_W-1:0] index,
                       input logic [PLANE_REG_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      tracker.store_register(index, value);
   endtask

   // left +x, right -x, top -y, bottom +y, near +z, far -z
   task load_axis_planes(input int fixed_width);
      int nrm [3];
      int width;
      for (int p = 0; p < NUM_PLANE_REGS; p++) begin
         nrm = '{0, 0, 0};
         nrm[p / 2] = (p == 0 || p == 3 || p == 4) ? NORM_ONE : -NORM_ONE;
         width = (fixed_width != 0) ? fixed_width : $urandom_range(16 * UNIT, 300 * UNIT);
         write_register(REG_PLANE_LEFT + CSR_IDX_W'(p), pack_plane(nrm[0], nrm[1], nrm[2], width));
      end
   endtask

   task load_phase(input int phase);
      plane_set_kind_type kind;
      logic [PLANE_REG_W-1:0] word;
      int pick [4];
      kind = plane_set_kind_type'(phase % 4);
      if (kind == PLANES_AXIS) begin
         load_axis_planes(0);
      end else begin
         for (int p = 0; p < NUM_PLANE_REGS; p++) begin
            for (int k = 0; k < 4; k++) begin
               if (kind == PLANES_TILTED) begin
                  pick[k] = (k < 3) ? int'($urandom_range(0, 2 * NORM_ONE)) - NORM_ONE
                                    : int'($urandom_range(0, 2 * UNIT * UNIT)) - UNIT * UNIT;
               end else begin
                  case ($urandom_range(2))
                     0: pick[k] = (k < 3) ? (1 << (NORM_W - 1)) - 1 : (1 << (OFFS_W - 1)) - 1;
                     1: pick[k] = (k < 3) ? -(1 << (NORM_W - 1)) : -(1 << (OFFS_W - 1));
                     default: pick[k] = 0;
                  endcase
               end
            end
            word = (kind == PLANES_RAW) ? {$urandom, $urandom}
                                         : pack_plane(pick[0], pick[1], pick[2], pick[3]);
            write_register(REG_PLANE_LEFT + CSR_IDX_W'(p), word);
         end
      end
      word = {$urandom, $urandom};
      case (phase)
         0, 3: word[MARGIN_W-1:0] = '0;
         2, 5, 6: word[MARGIN_W-1:0] = '1;
         default: word[MARGIN_W-1:0] = MARGIN_W'($urandom_range(0, 4096));
      endcase
      write_register(REG_OUTSIDE_MARGIN, word);
      csr_we <= 1'b0;
   endtask

   initial begin
      req_payload_type box;
      int mode;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.data = '0;
      sender_gaps = 0;
      receiver_stalls = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset planes are all zero: every box spans
      send_box({COORD_COUNT{COORD_MAX}});
      send_box({COORD_COUNT{COORD_MIN}});
      send_box('0);
      send_box({(COORD_COUNT / 2){COORD_MAX, COORD_MIN}});
      drain_results();

      // unit cube frustum, half width 100.0, margin 2.0
      load_axis_planes(100 * UNIT);
      write_register(REG_OUTSIDE_MARGIN, PLANE_REG_W'(MARGIN_RESET));
      csr_we <= 1'b0;
      box = '0;
      box.half_axis0_x = coord_type'(UNIT);
      box.half_axis1_y = coord_type'(UNIT);
      box.half_axis2_z = coord_type'(UNIT);
      send_box(box);
      send_box(box_at(-25599, 0, 0));
      send_box(box_at(-25600, 0, 0));
      send_box(box_at(-26112, 0, 0));
      send_box(box_at(-26113, 0, 0));
      box = box_at(-30000, 0, 0);
      box.half_axis0_y = coord_type'(100000);
      send_box(box);
      box = '0;
      box.half_axis0_x = coord_type'(25600);
      send_box(box);
      box.half_axis0_x = coord_type'(-25599);
      send_box(box);
      box = '0;
      box.half_axis1_z = coord_type'(-25600);
      send_box(box);
      drain_results();

      // ignored index, then an unnormalized left normal
      write_register(REG_UNMAPPED, '1);
      write_register(REG_PLANE_LEFT, pack_plane(2047, 0, 0, 100 * UNIT));
      csr_we <= 1'b0;
      send_box(box_at(-12500, 0, 0));
      send_box(box_at(-12900, 0, 0));
      send_box(box_at(-13200, 0, 0));
      drain_results();
      write_register(REG_OUTSIDE_MARGIN, '1);
      csr_we <= 1'b0;
      send_box(box_at(-13200, 0, 0));

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_results();
         load_phase(phase);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 50 == 0) begin
               mode = $urandom_range(3);
               sender_gaps = mode[0];
               receiver_stalls = mode[1];
            end
            if (n == ITEMS_PER_PHASE / 2 && phase % 2 == 0) drain_results();
            send_box(random_box());
         end
      end

      drain_results();
      repeat (4 * PIPE_LATENCY) @(posedge clock);
      if (tracker.pending() != 0) begin
         tracker.report_mismatch($sformatf("%0d classes never arrived", tracker.pending()));
      end
      if (tracker.mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

/* frustum_obb_classifier.f */
rtl/fobb_pkg.sv
rtl/fobb_if.sv
rtl/fobb_plane_eval.sv
rtl/frustum_obb_classifier.sv
bench/testbench.sv
